// ===== rtl/length_prefixed_request_deframer_unit_macros.svh =====
// assertion macros for the length prefixed request deframer
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_UNIT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define LPRD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// expression must hold at every clock edge out of reset
`define LPRD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

// ===== rtl/lprd_pkg.sv =====
// package with types, constants and helpers of the request deframer
`timescale 1ns / 1ps

package lprd_pkg;

  localparam int unsigned MAX_BODY   = 4096;
  localparam int unsigned MAX_ARGS   = 1024;
  localparam int unsigned BODY_W     = 13;
  localparam int unsigned ARGS_W     = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BODY_LEN  = 1'b0,
    CFG_MAX_ARG_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_COUNT   = 3'd1,
    PH_ARGLEN  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAIL   = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ARG      = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_BAD      = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_SET     = 2'd1,
    CMD_DEL     = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  arg_index;
    logic [7:0]        data_byte;
    cmd_e              command;
    logic [ARGS_W-1:0] arg_count;
    logic [BODY_W-1:0] body_length;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // lower-case letters of get, set and del
  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case ({w, pos})
      4'b00_00: c = 8'h67;
      4'b00_01: c = 8'h65;
      4'b00_10: c = 8'h74;
      4'b01_00: c = 8'h73;
      4'b01_01: c = 8'h65;
      4'b01_10: c = 8'h74;
      4'b10_00: c = 8'h64;
      4'b10_01: c = 8'h65;
      4'b10_10: c = 8'h6c;
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/lprd_parse.sv =====
// frame parser: state registers and per-byte decode of the request stream
`timescale 1ns / 1ps

module lprd_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lprd_pkg::BODY_W-1:0]    max_body_len_i,
  input  logic [lprd_pkg::ARGS_W-1:0]    max_arg_count_i,
  input  logic                           fire_i,
  input  logic [7:0]                     byte_i,
  output lprd_pkg::push_t                push_o
);

  lprd_pkg::phase_e                phase_q, phase_d;
  logic [23:0]                     shift_q, shift_d;
  logic [1:0]                      bcnt_q, bcnt_d;
  logic [lprd_pkg::BODY_W-1:0]     flen_q, flen_d;
  logic [lprd_pkg::BODY_W-1:0]     bpos_q, bpos_d;
  logic [lprd_pkg::ARGS_W-1:0]     aexp_q, aexp_d;
  logic [lprd_pkg::ARGS_W-1:0]     adone_q, adone_d;
  logic [lprd_pkg::BODY_W-1:0]     aleft_q, aleft_d;
  logic                            berr_q, berr_d;
  logic [lprd_pkg::BODY_W-1:0]     falen_q, falen_d;
  logic [2:0]                      wflags_q, wflags_d;

  logic [lprd_pkg::BODY_W-1:0]     body_lim;
  logic [lprd_pkg::ARGS_W-1:0]     args_lim;
  logic [23:0]                     shift_acc;
  logic                            field_done;
  logic [31:0]                     field_val;
  logic [lprd_pkg::BODY_W-1:0]     room;
  logic [lprd_pkg::BODY_W-1:0]     off;
  logic [7:0]                      lc;
  logic                            pay;
  lprd_pkg::res_t                  verdict;
  lprd_pkg::cmd_e                  cmd;
  logic                            three;

  assign body_lim = (max_body_len_i > lprd_pkg::BODY_W'(lprd_pkg::MAX_BODY)) ?
                    lprd_pkg::BODY_W'(lprd_pkg::MAX_BODY) : max_body_len_i;
  assign args_lim = (max_arg_count_i > lprd_pkg::ARGS_W'(lprd_pkg::MAX_ARGS)) ?
                    lprd_pkg::ARGS_W'(lprd_pkg::MAX_ARGS) : max_arg_count_i;

  assign field_done = (bcnt_q == 2'd3);
  assign field_val  = {byte_i, shift_q};

  always_comb begin
    shift_acc = shift_q;
    case (bcnt_q)
      2'd0:    shift_acc[7:0]   = byte_i;
      2'd1:    shift_acc[15:8]  = byte_i;
      2'd2:    shift_acc[23:16] = byte_i;
      default: shift_acc        = shift_q;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    bcnt_d   = bcnt_q;
    flen_d   = flen_q;
    bpos_d   = bpos_q;
    aexp_d   = aexp_q;
    adone_d  = adone_q;
    aleft_d  = aleft_q;
    berr_d   = berr_q;
    falen_d  = falen_q;
    wflags_d = wflags_q;
    push_o   = '0;
    room     = '0;
    off      = '0;
    lc       = byte_i;
    pay      = 1'b0;
    verdict  = '0;
    cmd      = lprd_pkg::CMD_UNKNOWN;
    three    = 1'b0;

    if (fire_i && phase_q == lprd_pkg::PH_LEN) begin
      if (field_done) begin
        shift_d = '0;
        bcnt_d  = '0;
        if (field_val > {19'd0, body_lim}) begin
          push_o.cnt     = 2'd1;
          push_o.r0.kind = lprd_pkg::KIND_TOO_LONG;
          push_o.r0.last = 1'b1;
          phase_d        = lprd_pkg::PH_CLOSED;
        end else if (field_val == 32'd0) begin
          push_o.cnt     = 2'd1;
          push_o.r0.kind = lprd_pkg::KIND_BAD;
          push_o.r0.last = 1'b1;
          phase_d        = lprd_pkg::PH_CLOSED;
        end else begin
          flen_d  = field_val[lprd_pkg::BODY_W-1:0];
          bpos_d  = '0;
          phase_d = lprd_pkg::PH_COUNT;
        end
      end else begin
        shift_d = shift_acc;
        bcnt_d  = bcnt_q + 2'd1;
      end
    end else if (fire_i && phase_q != lprd_pkg::PH_CLOSED) begin
      bpos_d = bpos_q + lprd_pkg::BODY_W'(1);
      room   = flen_q - bpos_d;
      if (!berr_q) begin
        case (phase_q)
          lprd_pkg::PH_COUNT: begin
            if (field_done) begin
              shift_d = '0;
              bcnt_d  = '0;
              if (field_val > {21'd0, args_lim}) begin
                berr_d = 1'b1;
              end else begin
                aexp_d  = field_val[lprd_pkg::ARGS_W-1:0];
                adone_d = '0;
                phase_d = (aexp_d != '0) ? lprd_pkg::PH_ARGLEN : lprd_pkg::PH_TRAIL;
              end
            end else begin
              shift_d = shift_acc;
              bcnt_d  = bcnt_q + 2'd1;
            end
          end
          lprd_pkg::PH_ARGLEN: begin
            if (field_done) begin
              shift_d = '0;
              bcnt_d  = '0;
              if (field_val > {19'd0, room}) begin
                berr_d = 1'b1;
              end else begin
                if (adone_q == '0) begin
                  falen_d = field_val[lprd_pkg::BODY_W-1:0];
                end
                if (field_val == 32'd0) begin
                  adone_d = adone_q + lprd_pkg::ARGS_W'(1);
                  phase_d = (adone_d < aexp_q) ? lprd_pkg::PH_ARGLEN : lprd_pkg::PH_TRAIL;
                end else begin
                  aleft_d = field_val[lprd_pkg::BODY_W-1:0];
                  phase_d = lprd_pkg::PH_PAYLOAD;
                end
              end
            end else begin
              shift_d = shift_acc;
              bcnt_d  = bcnt_q + 2'd1;
            end
          end
          lprd_pkg::PH_PAYLOAD: begin
            if (adone_q == '0) begin
              off = falen_q - aleft_q;
              lc  = (byte_i inside {[8'h41:8'h5a]}) ? byte_i + 8'h20 : byte_i;
              for (int w = 0; w < 3; w++) begin
                if (off >= lprd_pkg::BODY_W'(3) ||
                    lprd_pkg::word_char(2'(w), off[1:0]) != lc) begin
                  wflags_d[w] = 1'b0;
                end
              end
            end
            pay                 = 1'b1;
            push_o.r0.kind      = lprd_pkg::KIND_ARG;
            push_o.r0.arg_index = adone_q[lprd_pkg::IDX_W-1:0];
            push_o.r0.data_byte = byte_i;
            aleft_d             = aleft_q - lprd_pkg::BODY_W'(1);
            if (aleft_d == '0) begin
              adone_d = adone_q + lprd_pkg::ARGS_W'(1);
              phase_d = (adone_d < aexp_q) ? lprd_pkg::PH_ARGLEN : lprd_pkg::PH_TRAIL;
            end
          end
          lprd_pkg::PH_TRAIL: begin
            berr_d = 1'b1;
          end
          default: begin
            berr_d = berr_q;
          end
        endcase
      end

      if (bpos_d >= flen_q) begin
        verdict.last = 1'b1;
        if (!berr_d && phase_d == lprd_pkg::PH_TRAIL) begin
          three = (falen_d == lprd_pkg::BODY_W'(3));
          if (adone_d == lprd_pkg::ARGS_W'(2) && three && wflags_d[0]) begin
            cmd = lprd_pkg::CMD_GET;
          end else if (adone_d == lprd_pkg::ARGS_W'(3) && three && wflags_d[1]) begin
            cmd = lprd_pkg::CMD_SET;
          end else if (adone_d == lprd_pkg::ARGS_W'(2) && three && wflags_d[2]) begin
            cmd = lprd_pkg::CMD_DEL;
          end else begin
            cmd = lprd_pkg::CMD_UNKNOWN;
          end
          verdict.kind        = lprd_pkg::KIND_ACCEPT;
          verdict.command     = cmd;
          verdict.arg_count   = adone_d;
          verdict.body_length = flen_q;
          // start of the next frame
          phase_d  = lprd_pkg::PH_LEN;
          shift_d  = '0;
          bcnt_d   = '0;
          flen_d   = '0;
          bpos_d   = '0;
          aexp_d   = '0;
          adone_d  = '0;
          aleft_d  = '0;
          berr_d   = 1'b0;
          falen_d  = '0;
          wflags_d = 3'b111;
        end else begin
          verdict.kind        = lprd_pkg::KIND_BAD;
          verdict.body_length = flen_q;
          phase_d             = lprd_pkg::PH_CLOSED;
        end
        if (pay) begin
          push_o.cnt = 2'd2;
          push_o.r1  = verdict;
        end else begin
          push_o.cnt = 2'd1;
          push_o.r0  = verdict;
        end
      end else if (pay) begin
        push_o.cnt     = 2'd1;
        push_o.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lprd_pkg::PH_LEN;
      shift_q  <= '0;
      bcnt_q   <= '0;
      flen_q   <= '0;
      bpos_q   <= '0;
      aexp_q   <= '0;
      adone_q  <= '0;
      aleft_q  <= '0;
      berr_q   <= 1'b0;
      falen_q  <= '0;
      wflags_q <= 3'b111;
    end else begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      bcnt_q   <= bcnt_d;
      flen_q   <= flen_d;
      bpos_q   <= bpos_d;
      aexp_q   <= aexp_d;
      adone_q  <= adone_d;
      aleft_q  <= aleft_d;
      berr_q   <= berr_d;
      falen_q  <= falen_d;
      wflags_q <= wflags_d;
    end
  end

endmodule

// ===== rtl/lprd_fifo.sv =====
// result queue taking up to two results per cycle and giving one
`timescale 1ns / 1ps

module lprd_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lprd_pkg::push_t             push_i,
  input  logic                        pop_i,
  output lprd_pkg::res_t              head_o,
  output logic                        not_empty_o,
  output logic                        room2_o,
  output logic [lprd_pkg::LVL_W-1:0]  level_o
);

  lprd_pkg::res_t                 mem [lprd_pkg::FIFO_DEPTH];
  logic [lprd_pkg::PTR_W-1:0]     wptr_q, wptr_d;
  logic [lprd_pkg::PTR_W-1:0]     rptr_q, rptr_d;
  logic [lprd_pkg::LVL_W-1:0]     count_q, count_d;

  assign wptr_d  = wptr_q + lprd_pkg::PTR_W'(push_i.cnt);
  assign rptr_d  = rptr_q + lprd_pkg::PTR_W'(pop_i);
  assign count_d = count_q + lprd_pkg::LVL_W'(push_i.cnt) - lprd_pkg::LVL_W'(pop_i);

  assign head_o      = mem[rptr_q];
  assign not_empty_o = (count_q != '0);
  assign room2_o     = (count_q <= lprd_pkg::LVL_W'(lprd_pkg::FIFO_DEPTH - 2));
  assign level_o     = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wptr_q + lprd_pkg::PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/length_prefixed_request_deframer_unit.sv =====
// top level of the length prefixed request deframer
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_byte_i
//   out      output     out_valid_o / out_stall_i kind, arg_index, data_byte, command,
//                                                 arg_count, body_length, last
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte per cycle while the queue has room for two results: a byte is held in the
// input register, is decoded from it and its results enter a four-entry queue; the first
// result shows in the cycle after the byte is decoded, if the queue was empty
// a byte that ends a frame with a payload byte yields two results, which drain at
// one per cycle while out_stall_i is low, through the single queue read port
// input stalls only while the queue holds more than two results
// reset clears parser state, the queue and the limits to 4096 and 1024
`timescale 1ns / 1ps
`include "length_prefixed_request_deframer_unit_macros.svh"

module length_prefixed_request_deframer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         in_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [lprd_pkg::IDX_W-1:0]         arg_index_o,
  output logic [7:0]                         data_byte_o,
  output logic [1:0]                         command_o,
  output logic [lprd_pkg::ARGS_W-1:0]        arg_count_o,
  output logic [lprd_pkg::BODY_W-1:0]        body_length_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lprd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lprd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [lprd_pkg::BODY_W-1:0]    max_body_len_q;
  logic [lprd_pkg::ARGS_W-1:0]    max_arg_count_q;
  logic                           in_vld_q, in_vld_d;
  logic [7:0]                     in_byte_q;
  logic                           in_take;
  logic                           proc;
  logic                           pop;
  logic                           room2;
  logic                           not_empty;
  logic [lprd_pkg::LVL_W-1:0]     level;
  lprd_pkg::push_t                push;
  lprd_pkg::res_t                 head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_len_q  <= lprd_pkg::BODY_W'(4096);
      max_arg_count_q <= lprd_pkg::ARGS_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lprd_pkg::CFG_MAX_BODY_LEN:  max_body_len_q  <= cfg_data_i[lprd_pkg::BODY_W-1:0];
        lprd_pkg::CFG_MAX_ARG_COUNT: max_arg_count_q <= cfg_data_i[lprd_pkg::ARGS_W-1:0];
        default:                     max_body_len_q  <= max_body_len_q;
      endcase
    end
  end

  // input register
  assign proc       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take ? 1'b1 : (proc ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
  end

  lprd_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_body_len_i  (max_body_len_q),
    .max_arg_count_i (max_arg_count_q),
    .fire_i          (proc),
    .byte_i          (in_byte_q),
    .push_o          (push)
  );

  lprd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room2_o     (room2),
    .level_o     (level)
  );

  assign out_valid_o   = not_empty;
  assign pop           = not_empty && !out_stall_i;
  assign kind_o        = head.kind;
  assign arg_index_o   = head.arg_index;
  assign data_byte_o   = head.data_byte;
  assign command_o     = head.command;
  assign arg_count_o   = head.arg_count;
  assign body_length_o = head.body_length;
  assign last_o        = head.last;

  `LPRD_ASSERT_IMPL(a_pair_order, push.cnt == 2'd2, !push.r0.last && push.r1.last, "two results of one transaction out of order")
  `LPRD_ASSERT_IMPL(a_single_last, push.cnt == 2'd1, push.r0.last, "single result of a transaction not marked last")
  `LPRD_ASSERT_ALWAYS(a_no_overflow, level <= lprd_pkg::LVL_W'(lprd_pkg::FIFO_DEPTH), "result queue overflow")

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the length prefixed request deframer
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_BYTES = 900;

  class deframe_tracker;
    logic [lprd_pkg::BODY_W-1:0] body_reg;
    logic [lprd_pkg::ARGS_W-1:0] args_reg;
    lprd_pkg::phase_e            parse_phase;
    logic [31:0]                 shift_acc;
    logic [1:0]                  acc_bytes;
    int unsigned                 body_len;
    int unsigned                 body_pos;
    int unsigned                 arg_total;
    int unsigned                 arg_seen;
    int unsigned                 arg_left;
    int unsigned                 arg0_len;
    bit                          frame_bad;
    logic [2:0]                  word_hits;
    string                       cmd_words[3];
    lprd_pkg::res_t              pending_results[$];
    int unsigned                 fail_count;

    function new();
      cmd_words[0] = "get";
      cmd_words[1] = "set";
      cmd_words[2] = "del";
      body_reg = 13'd4096;
      args_reg = 11'd1024;
      fail_count = 0;
      reset_frame();
    endfunction

    function void reset_frame();
      parse_phase = lprd_pkg::PH_LEN;
      shift_acc = '0;
      acc_bytes = '0;
      body_len = 0;
      body_pos = 0;
      arg_total = 0;
      arg_seen = 0;
      arg_left = 0;
      frame_bad = 1'b0;
      arg0_len = 0;
      word_hits = 3'b111;
    endfunction

    function void set_limit(lprd_pkg::cfg_reg_e idx, int unsigned value);
      if (idx == lprd_pkg::CFG_MAX_BODY_LEN) body_reg = lprd_pkg::BODY_W'(value);
      else args_reg = lprd_pkg::ARGS_W'(value);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function bit shift_byte(logic [7:0] b);
      shift_acc = shift_acc | (32'(b) << (8 * acc_bytes));
      acc_bytes = acc_bytes + 2'd1;
      return acc_bytes == 2'd0;
    endfunction

    function void after_arg();
      if (arg_seen < arg_total) parse_phase = lprd_pkg::PH_ARGLEN;
      else parse_phase = lprd_pkg::PH_TRAIL;
    endfunction

    function lprd_pkg::cmd_e command_class();
      bit three;
      three = arg0_len == 3;
      if (arg_seen == 2 && three && word_hits[0]) return lprd_pkg::CMD_GET;
      if (arg_seen == 3 && three && word_hits[1]) return lprd_pkg::CMD_SET;
      if (arg_seen == 2 && three && word_hits[2]) return lprd_pkg::CMD_DEL;
      return lprd_pkg::CMD_UNKNOWN;
    endfunction

    function void add_result(lprd_pkg::kind_e k, int unsigned idx, logic [7:0] data,
                             lprd_pkg::cmd_e c, int unsigned cnt, int unsigned blen,
                             bit fin);
      lprd_pkg::res_t r;
      r.kind = k;
      r.arg_index = lprd_pkg::IDX_W'(idx);
      r.data_byte = data;
      r.command = c;
      r.arg_count = lprd_pkg::ARGS_W'(cnt);
      r.body_length = lprd_pkg::BODY_W'(blen);
      r.last = fin;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned body_lim;
      int unsigned args_lim;
      int unsigned val;
      int unsigned off;
      logic [7:0]  lower;
      int          w;
      body_lim = (body_reg < lprd_pkg::MAX_BODY) ? body_reg : lprd_pkg::MAX_BODY;
      args_lim = (args_reg < lprd_pkg::MAX_ARGS) ? args_reg : lprd_pkg::MAX_ARGS;
      if (parse_phase == lprd_pkg::PH_LEN) begin
        if (shift_byte(b)) begin
          val = shift_acc;
          shift_acc = '0;
          if (val > body_lim) begin
            add_result(lprd_pkg::KIND_TOO_LONG, 0, 8'h00, lprd_pkg::CMD_GET, 0, 0, 1'b1);
            parse_phase = lprd_pkg::PH_CLOSED;
          end else if (val == 0) begin
            add_result(lprd_pkg::KIND_BAD, 0, 8'h00, lprd_pkg::CMD_GET, 0, 0, 1'b1);
            parse_phase = lprd_pkg::PH_CLOSED;
          end else begin
            body_len = val;
            body_pos = 0;
            parse_phase = lprd_pkg::PH_COUNT;
          end
        end
        return;
      end
      if (parse_phase == lprd_pkg::PH_CLOSED) return;
      body_pos++;
      if (!frame_bad) begin
        case (parse_phase)
          lprd_pkg::PH_COUNT: begin
            if (shift_byte(b)) begin
              val = shift_acc;
              shift_acc = '0;
              if (val > args_lim) begin
                frame_bad = 1'b1;
              end else begin
                arg_total = val;
                arg_seen = 0;
                after_arg();
              end
            end
          end
          lprd_pkg::PH_ARGLEN: begin
            if (shift_byte(b)) begin
              val = shift_acc;
              shift_acc = '0;
              if (val > body_len - body_pos) begin
                frame_bad = 1'b1;
              end else begin
                if (arg_seen == 0) arg0_len = val;
                if (val == 0) begin
                  arg_seen++;
                  after_arg();
                end else begin
                  arg_left = val;
                  parse_phase = lprd_pkg::PH_PAYLOAD;
                end
              end
            end
          end
          lprd_pkg::PH_PAYLOAD: begin
            if (arg_seen == 0) begin
              off = arg0_len - arg_left;
              lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
              for (w = 0; w < 3; w++) begin
                if (off >= 3 || cmd_words[w][off] != lower) word_hits[w] = 1'b0;
              end
            end
            // the verdict follows when this byte closes the frame
            add_result(lprd_pkg::KIND_ARG, arg_seen, b, lprd_pkg::CMD_GET, 0, 0,
                       body_pos < body_len);
            arg_left--;
            if (arg_left == 0) begin
              arg_seen++;
              after_arg();
            end
          end
          default: begin
            frame_bad = 1'b1;
          end
        endcase
      end
      if (body_pos >= body_len) begin
        if (!frame_bad && parse_phase == lprd_pkg::PH_TRAIL) begin
          add_result(lprd_pkg::KIND_ACCEPT, 0, 8'h00, command_class(), arg_seen, body_len,
                     1'b1);
          reset_frame();
        end else begin
          add_result(lprd_pkg::KIND_BAD, 0, 8'h00, lprd_pkg::CMD_GET, 0, body_len, 1'b1);
          parse_phase = lprd_pkg::PH_CLOSED;
        end
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void compare_result(lprd_pkg::res_t got);
      lprd_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("output transaction with nothing outstanding, kind %0d", got.kind);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      field_check("kind", want.kind, got.kind);
      field_check("arg_index", want.arg_index, got.arg_index);
      field_check("data_byte", want.data_byte, got.data_byte);
      field_check("command", want.command, got.command);
      field_check("arg_count", want.arg_count, got.arg_count);
      field_check("body_length", want.body_length, got.body_length);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      in_byte_i = 8'h00;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      kind_o;
  logic [lprd_pkg::IDX_W-1:0]      arg_index_o;
  logic [7:0]                      data_byte_o;
  logic [1:0]                      command_o;
  logic [lprd_pkg::ARGS_W-1:0]     arg_count_o;
  logic [lprd_pkg::BODY_W-1:0]     body_length_o;
  logic                            last_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [lprd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lprd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  deframe_tracker tracker;
  logic [7:0]     body_bytes[$];
  int unsigned    bytes_sent = 0;
  int unsigned    cycle_count = 0;
  int unsigned    args_setting = 1024;
  bit             tx_idle = 1'b1;
  bit             long_hold = 1'b0;

  length_prefixed_request_deframer_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("length_prefixed_request_deframer_unit regression: fail");
      $finish;
    end
  end

  // check each output transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.compare_result(lprd_pkg::res_t'({kind_o, arg_index_o, data_byte_o, command_o,
                                               arg_count_o, body_length_o, last_o}));
    end
  end

  initial begin
    int unsigned pause;
    bit          rx_idle;
    rx_idle = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      pause = rx_idle ? $urandom_range(0, 5) : 0;
      if (long_hold) begin
        pause = 300;
        long_hold = 1'b0;
      end
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned header);
    logic [31:0] h;
    h = header;
    tx_idle = $urandom_range(0, 2) != 0;
    for (int i = 0; i < 4; i++) send_byte(h[8*i +: 8]);
    foreach (body_bytes[i]) send_byte(body_bytes[i]);
    body_bytes.delete();
  endtask

  task automatic wait_idle();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (tracker.pending() > 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_limits(input int unsigned body_max, input int unsigned args_max);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= lprd_pkg::CFG_MAX_BODY_LEN;
    cfg_data_i <= lprd_pkg::CFG_DATA_W'(body_max);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_limit(lprd_pkg::CFG_MAX_BODY_LEN, body_max);
    cfg_index_i <= lprd_pkg::CFG_MAX_ARG_COUNT;
    cfg_data_i <= lprd_pkg::CFG_DATA_W'(args_max);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_limit(lprd_pkg::CFG_MAX_ARG_COUNT, args_max);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void append_byte(logic [7:0] b);
    body_bytes.insert(body_bytes.size(), b);
  endfunction

  function automatic void put_word(int unsigned v);
    for (int i = 0; i < 4; i++) append_byte(v[8*i +: 8]);
  endfunction

  function automatic void put_text(string s);
    put_word(s.len());
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void put_random_arg(int unsigned max_len);
    int unsigned n;
    n = $urandom_range(0, max_len);
    put_word(n);
    repeat (n) append_byte(8'($urandom));
  endfunction

  // command word in random case, sometimes spoiled
  function automatic void put_command(string s);
    logic [7:0] c[$];
    for (int i = 0; i < s.len(); i++) begin
      c.insert(c.size(), s[i] ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: c[$urandom_range(0, 2)] = 8'($urandom);
        1: c.insert(c.size(), 8'($urandom));
        2: void'(c.pop_back());
        default: c[$urandom_range(0, 2)] = 8'h00;
      endcase
    end
    put_word(c.size());
    foreach (c[i]) append_byte(c[i]);
  endfunction

  function automatic void build_request(int unsigned args_cap);
    int unsigned form;
    int unsigned nargs;
    string       word;
    form = $urandom_range(0, 5);
    case (form)
      0: begin
        nargs = 2;
        word = "get";
      end
      1: begin
        nargs = 3;
        word = "set";
      end
      2: begin
        nargs = 2;
        word = "del";
      end
      3: begin
        nargs = $urandom_range(0, 6);
        word = "";
      end
      default: begin
        nargs = $urandom_range(1, 4);
        word = (form == 4) ? "del" : "set";
      end
    endcase
    if (nargs > args_cap) nargs = args_cap;
    put_word(nargs);
    for (int i = 0; i < nargs; i++) begin
      if (i == 0 && word.len() > 0) put_command(word);
      else put_random_arg(8);
    end
  endfunction

  initial begin
    int unsigned lim;
    int unsigned hdr;
    int unsigned stop_at;
    int unsigned k;
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    set_limits(8191, 2047);

    put_word(2); put_text("GeT"); put_text("key");
    send_frame(body_bytes.size());
    put_word(3); put_text("sEt"); put_text("k"); put_word(4);
    append_byte(8'hFF); append_byte(8'h00);
    append_byte(8'hFF); append_byte(8'h00);
    send_frame(body_bytes.size());
    put_word(2); put_text("DEL"); put_word(0);
    send_frame(body_bytes.size());
    put_word(2); put_word(3);
    append_byte("g"); append_byte("e"); append_byte(8'h00);
    put_text("x");
    send_frame(body_bytes.size());
    put_word(2); put_text("gets"); put_text("x");
    send_frame(body_bytes.size());
    put_word(0);
    send_frame(body_bytes.size());
    put_word(3); put_text("get"); put_text("a"); put_text("b");
    send_frame(body_bytes.size());
    put_word(1); put_word(0);
    send_frame(body_bytes.size());
    // long run of empty arguments closed by one payload argument
    put_word(130);
    repeat (129) put_word(0);
    put_word(4);
    append_byte(8'hFF); append_byte(8'h00);
    append_byte(8'hA5); append_byte(8'h5A);
    send_frame(body_bytes.size());

    // body limit equal to the frame, no arguments allowed
    wait_idle();
    set_limits(4, 0);
    repeat (3) begin
      put_word(0);
      send_frame(body_bytes.size());
    end

    for (k = 0; k < 4; k++) begin
      wait_idle();
      if (k == 0) begin
        lim = 4096;
        args_setting = 1024;
      end else begin
        lim = $urandom_range(80, 8191);
        args_setting = $urandom_range(6, 2047);
      end
      set_limits(lim, args_setting);
      if (k == 1 || k == 3) long_hold = 1'b1;
      stop_at = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < stop_at) begin
        build_request(args_setting);
        send_frame(body_bytes.size());
      end
    end

    // one closing error per run, then the block ignores everything
    wait_idle();
    case ($urandom_range(0, 5))
      0: begin
        lim = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4096);
        set_limits(lim, args_setting);
        hdr = $urandom_range(0, 1) ? ($urandom() | 32'h8000_0000)
                                   : lim + 1 + $urandom_range(0, 64);
        repeat (8) append_byte(8'($urandom));
        send_frame(hdr);
      end
      1: begin
        send_frame(0);
      end
      2: begin
        lim = (args_setting < lprd_pkg::MAX_ARGS) ? args_setting : lprd_pkg::MAX_ARGS;
        put_word(lim + 1 + $urandom_range(0, 64));
        repeat (4) append_byte(8'($urandom));
        send_frame(body_bytes.size());
      end
      3: begin
        put_word(1);
        put_word(50 + $urandom_range(0, 200));
        repeat (5) append_byte(8'($urandom));
        send_frame(body_bytes.size());
      end
      4: begin
        put_word(2); put_text("get"); put_random_arg(4);
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
        send_frame(body_bytes.size());
      end
      default: begin
        repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
        send_frame(body_bytes.size());
      end
    endcase
    repeat (16) send_byte(8'($urandom));

    wait_idle();
    if (tracker.pending() != 0) begin
      $error("%0d predicted results never arrived", tracker.pending());
      tracker.fail_count++;
    end
    if (tracker.fail_count == 0) begin
      $display("length_prefixed_request_deframer_unit regression: pass");
    end else begin
      $display("length_prefixed_request_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
